// ===== hw/rtl/fifo_reader_writer_lock_macros.svh =====
// Assertion macros for the reader-writer lock RTL.
`ifndef FIFO_READER_WRITER_LOCK_MACROS_SVH
`define FIFO_READER_WRITER_LOCK_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define FRWL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frwl assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FRWL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frwl assertion failed");

`else

`define FRWL_ASSERT_IMP(label, clk, rst, ante, cons)
`define FRWL_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/frwl_pkg.sv =====
// Types, constants and helpers shared by the reader-writer lock modules.
package frwl_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int NUM_REQUESTERS = 64;
   localparam int MAX_READERS    = 255;

   localparam int ID_W   = 6;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int RD_W   = $clog2(MAX_READERS + 1);

   localparam logic MODE_EXCL   = 1'b0;
   localparam logic MODE_SHARED = 1'b1;

   typedef enum logic [2:0] {
      CMD_LOCK_EXCL     = 3'd0,
      CMD_LOCK_SHARED   = 3'd1,
      CMD_TRY_EXCL      = 3'd2,
      CMD_TRY_SHARED    = 3'd3,
      CMD_UNLOCK_EXCL   = 3'd4,
      CMD_UNLOCK_SHARED = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      STS_GRANTED   = 3'd0,
      STS_QUEUED    = 3'd1,
      STS_REFUSED   = 3'd2,
      STS_NO_ROOM   = 3'd3,
      STS_RELEASED  = 3'd4,
      STS_REL_ERROR = 3'd5,
      STS_WOKEN     = 3'd6
   } status_type;

   // One waiting requester: its mode and its id.
   typedef struct packed {
      logic            mode;
      logic [ID_W-1:0] id;
   } entry_type;

   // Write port of the wait queue memory.
   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      entry_type        data;
   } wr_type;

   // Advances a queue pointer with wrap at the queue depth.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

   // Low eight bits of the reader count, zero extended where the count is narrow.
   function automatic logic [7:0] readers_out(input logic [RD_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[7:0];
   endfunction

endpackage

// ===== hw/rtl/frwl_wait_mem.sv =====
// Wait queue storage: one write port, one read port with registered data.
module frwl_wait_mem (
   input  logic                          clock,
   input  frwl_pkg::wr_type              wr,
   input  logic [frwl_pkg::PTR_W-1:0]    rd_addr,
   output frwl_pkg::entry_type           rd_data
);

   frwl_pkg::entry_type mem [frwl_pkg::QUEUE_DEPTH];
   frwl_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fifo_reader_writer_lock.sv =====
// Fair reader-writer lock manager with a FIFO of waiters and direct hand-off.
// Lock, try and failed unlock commands: one result on the cycle after the transfer; busy
// stays low, so such a command may be transferred in every cycle.
// A good unlock raises busy for its wake walk, which ends when no further waiter can be
// granted; its release result passes through the hold and result registers, and each woken
// grant follows one per cycle, set by one read of the wait queue memory per cycle.
// Reset clears the writer flag, reader count and queue pointers; the memory is not cleared.
`include "fifo_reader_writer_lock_macros.svh"

module fifo_reader_writer_lock (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic [5:0] req_requester,
   output logic       rsp_valid,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_grant_id,
   output logic       rsp_grant_shared,
   output logic [7:0] rsp_readers_now,
   output logic       rsp_writer_now,
   output logic       rsp_last
);

   typedef enum logic {
      ST_IDLE,
      ST_WAKE
   } state_type;

   // Controller state. The lock state proper is the writer flag, the reader count and
   // the queue pointers; the queued entries live in the memory instance below.
   state_type                       state_ff, state_in;
   logic                            writer_ff, writer_in;
   logic [frwl_pkg::RD_W-1:0]       readers_ff, readers_in;
   logic [frwl_pkg::PTR_W-1:0]      head_ff, head_in;
   logic [frwl_pkg::PTR_W-1:0]      tail_ff, tail_in;
   logic [frwl_pkg::FILL_W-1:0]     fill_ff, fill_in;

   // A result is held back in the hold registers during a wake walk, because its last flag is
   // only known once the next queue entry has been examined.
   frwl_pkg::status_type            hold_status_ff, hold_status_in;
   logic [frwl_pkg::ID_W-1:0]       hold_id_ff, hold_id_in;
   logic                            hold_shared_ff, hold_shared_in;
   logic [frwl_pkg::RD_W-1:0]       hold_readers_ff, hold_readers_in;
   logic                            hold_writer_ff, hold_writer_in;

   // Registered result port.
   logic                            rsp_valid_ff, rsp_valid_in;
   frwl_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [frwl_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                            rsp_shared_ff, rsp_shared_in;
   logic [frwl_pkg::RD_W-1:0]       rsp_readers_ff, rsp_readers_in;
   logic                            rsp_writer_ff, rsp_writer_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            accept;
   logic                            req_shared;
   logic                            id_bad;
   logic                            free_now;
   logic                            at_max;
   logic                            grant;
   frwl_pkg::entry_type             front;
   frwl_pkg::wr_type                mem_wr;

   // The memory read address follows the next head pointer in every cycle, so the entry
   // at the queue front is in the read register when a wake walk needs it. Entries are
   // written only by lock commands, which never start a wake walk, and a wake walk starts
   // in the cycle after the unlock transfer, so every write has landed before it is read.
   frwl_wait_mem u_wait_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (head_in),
      .rd_data (front)
   );

   assign busy       = (state_ff == ST_WAKE);
   assign accept     = start && !busy;
   assign req_shared = req_cmd[0];
   assign id_bad     = (int'(req_requester) >= frwl_pkg::NUM_REQUESTERS);
   assign at_max     = (readers_ff >= frwl_pkg::RD_W'(frwl_pkg::MAX_READERS));
   assign free_now   = !writer_ff && (fill_ff == '0) && (req_shared || (readers_ff == '0));

   // A waiter at the front can be handed the lock: shared waiters while the reader count
   // is below its limit, an exclusive waiter only once all readers have left.
   always_comb begin
      grant = 1'b0;
      if ((fill_ff != '0) && !writer_ff) begin
         if (front.mode == frwl_pkg::MODE_SHARED) begin
            grant = !at_max;
         end else begin
            grant = (readers_ff == '0);
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      writer_in       = writer_ff;
      readers_in      = readers_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      fill_in         = fill_ff;
      hold_status_in  = hold_status_ff;
      hold_id_in      = hold_id_ff;
      hold_shared_in  = hold_shared_ff;
      hold_readers_in = hold_readers_ff;
      hold_writer_in  = hold_writer_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_shared_in   = rsp_shared_ff;
      rsp_readers_in  = rsp_readers_ff;
      rsp_writer_in   = rsp_writer_ff;
      rsp_last_in     = rsp_last_ff;
      mem_wr.en       = 1'b0;
      mem_wr.addr     = tail_ff;
      mem_wr.data     = '{mode: req_shared, id: req_requester};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_id_in     = req_requester;
               rsp_shared_in = req_shared;
               rsp_status_in = frwl_pkg::STS_REFUSED;
               if (!id_bad) begin
                  case (req_cmd)
                     frwl_pkg::CMD_LOCK_EXCL, frwl_pkg::CMD_LOCK_SHARED,
                     frwl_pkg::CMD_TRY_EXCL, frwl_pkg::CMD_TRY_SHARED: begin
                        if (free_now && req_shared && at_max) begin
                           rsp_status_in = frwl_pkg::STS_NO_ROOM;
                        end else if (free_now) begin
                           rsp_status_in = frwl_pkg::STS_GRANTED;
                           if (req_shared) begin
                              readers_in = readers_ff + frwl_pkg::RD_W'(1);
                           end else begin
                              writer_in = 1'b1;
                           end
                        end else if (req_cmd[1]) begin
                           // Try commands that would have to wait are refused.
                           rsp_status_in = frwl_pkg::STS_REFUSED;
                        end else if (fill_ff >= frwl_pkg::FILL_W'(frwl_pkg::QUEUE_DEPTH)) begin
                           rsp_status_in = frwl_pkg::STS_NO_ROOM;
                        end else begin
                           rsp_status_in = frwl_pkg::STS_QUEUED;
                           mem_wr.en     = 1'b1;
                           tail_in       = frwl_pkg::ptr_next(tail_ff);
                           fill_in       = fill_ff + frwl_pkg::FILL_W'(1);
                        end
                     end
                     frwl_pkg::CMD_UNLOCK_EXCL: begin
                        rsp_shared_in = 1'b0;
                        if (!writer_ff) begin
                           rsp_status_in = frwl_pkg::STS_REL_ERROR;
                        end else begin
                           writer_in    = 1'b0;
                           rsp_valid_in = 1'b0;
                           state_in     = ST_WAKE;
                        end
                     end
                     frwl_pkg::CMD_UNLOCK_SHARED: begin
                        rsp_shared_in = 1'b1;
                        if (writer_ff || (readers_ff == '0)) begin
                           rsp_status_in = frwl_pkg::STS_REL_ERROR;
                        end else begin
                           readers_in   = readers_ff - frwl_pkg::RD_W'(1);
                           rsp_valid_in = 1'b0;
                           state_in     = ST_WAKE;
                        end
                     end
                     default: begin
                        rsp_status_in = frwl_pkg::STS_REFUSED;
                     end
                  endcase
               end
               rsp_readers_in = readers_in;
               rsp_writer_in  = writer_in;
               // A good unlock parks its release result until the wake walk knows
               // whether a grant follows it.
               hold_status_in  = frwl_pkg::STS_RELEASED;
               hold_id_in      = req_requester;
               hold_shared_in  = req_shared;
               hold_readers_in = readers_in;
               hold_writer_in  = writer_in;
            end
         end
         ST_WAKE: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = hold_status_ff;
            rsp_id_in      = hold_id_ff;
            rsp_shared_in  = hold_shared_ff;
            rsp_readers_in = hold_readers_ff;
            rsp_writer_in  = hold_writer_ff;
            rsp_last_in    = !grant;
            if (grant) begin
               if (front.mode == frwl_pkg::MODE_SHARED) begin
                  readers_in = readers_ff + frwl_pkg::RD_W'(1);
               end else begin
                  writer_in = 1'b1;
               end
               head_in         = frwl_pkg::ptr_next(head_ff);
               fill_in         = fill_ff - frwl_pkg::FILL_W'(1);
               hold_status_in  = frwl_pkg::STS_WOKEN;
               hold_id_in      = front.id;
               hold_shared_in  = front.mode;
               hold_readers_in = readers_in;
               hold_writer_in  = writer_in;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         writer_ff    <= 1'b0;
         readers_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         writer_ff    <= writer_in;
         readers_ff   <= readers_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_status_ff  <= hold_status_in;
      hold_id_ff      <= hold_id_in;
      hold_shared_ff  <= hold_shared_in;
      hold_readers_ff <= hold_readers_in;
      hold_writer_ff  <= hold_writer_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_shared_ff   <= rsp_shared_in;
      rsp_readers_ff  <= rsp_readers_in;
      rsp_writer_ff   <= rsp_writer_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_grant_id     = rsp_id_ff;
   assign rsp_grant_shared = rsp_shared_ff;
   assign rsp_readers_now  = frwl_pkg::readers_out(rsp_readers_ff);
   assign rsp_writer_now   = rsp_writer_ff;
   assign rsp_last         = rsp_last_ff;

   // A writer and readers never hold the lock at the same time.
   `FRWL_ASSERT_IMP(a_writer_excludes_readers, clock, reset, writer_ff, readers_ff == '0)
   // The fill count never passes the queue depth.
   `FRWL_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1,
                    fill_ff <= frwl_pkg::FILL_W'(frwl_pkg::QUEUE_DEPTH))
   // An empty queue has its pointers together.
   `FRWL_ASSERT_IMP(a_empty_ptrs, clock, reset, fill_ff == '0, head_ff == tail_ff)
   // A wake walk that grants nothing more closes with the final result of the unlock.
   `FRWL_ASSERT_NXT(a_wake_end, clock, reset, (state_ff == ST_WAKE) && !grant,
                    rsp_valid && rsp_last && !busy)

endmodule
